// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/blsu_pkg.sv -----
`timescale 1ns / 1ps

package blsu_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Clip registers
  localparam int unsigned CLIP_W = 11;
  localparam logic [CLIP_W-1:0] CLIP_RESET = 11'd2047;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ----- hw/rtl/bresenham_line_stepper_unit.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i / in_ready_o | x_start_i y_start_i x_end_i y_end_i
// out     | output    | out_valid_o/out_ready_i | pixel_x_o pixel_y_o in_window_o
//         |           |                         | last_point_o span_error_o
// cfg     | input     | cfg_we_i                | cfg_idx_i cfg_wdata_i
//
// A line is first loaded from the input word, then its points come one per cycle from the
// stepping registers while out_ready_i is high; a line has up to MAX_POINTS points.
// A line with a span above MAX_POINTS - 1 gives one error word after the load cycle.
// in_ready_o is high only while no line is in flight.
// A stall on out_ready_i holds the current point; reset returns to idle, clip = 2047.

`include "assert_macros.svh"

module bresenham_line_stepper_unit #(
  parameter int unsigned COORD_BITS = blsu_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_POINTS = blsu_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [blsu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [blsu_pkg::CLIP_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COORD_BITS-1:0]   x_start_i,
  input  logic signed [COORD_BITS-1:0]   y_start_i,
  input  logic signed [COORD_BITS-1:0]   x_end_i,
  input  logic signed [COORD_BITS-1:0]   y_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [COORD_BITS-1:0]   pixel_x_o,
  output logic signed [COORD_BITS-1:0]   pixel_y_o,
  output logic                           in_window_o,
  output logic                           last_point_o,
  output logic                           span_error_o
);

  blsu_pkg::cmd_t    cmd;
  blsu_pkg::status_t status;

  blsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  blsu_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .in_window_o  (in_window_o),
    .last_point_o (last_point_o),
    .span_error_o (span_error_o)
  );

  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "accept while emitting")
  `ASSERT_NEXT(a_load_emits, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "no word after load")
  `ASSERT_IMPL(a_err_is_last, clk_i, rst_ni, out_valid_o && span_error_o, last_point_o && !in_window_o, "error word not last")
  `ASSERT_NEXT(a_last_idles, clk_i, rst_ni, out_valid_o && out_ready_i && last_point_o, in_ready_o, "no idle after last")

endmodule

// ----- hw/rtl/blsu_ctrl.sv -----
`timescale 1ns / 1ps

module blsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  blsu_pkg::status_t status_i,
  output blsu_pkg::cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.step  = out_valid_o && out_ready_i && !status_i.last;

endmodule

// ----- hw/rtl/blsu_datapath.sv -----
`timescale 1ns / 1ps

module blsu_datapath #(
  parameter int unsigned COORD_BITS = blsu_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_POINTS = blsu_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [blsu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [blsu_pkg::CLIP_W-1:0]     cfg_wdata_i,
  input  blsu_pkg::cmd_t                  cmd_i,
  output blsu_pkg::status_t               status_o,
  input  logic signed [COORD_BITS-1:0]    x_start_i,
  input  logic signed [COORD_BITS-1:0]    y_start_i,
  input  logic signed [COORD_BITS-1:0]    x_end_i,
  input  logic signed [COORD_BITS-1:0]    y_end_i,
  output logic signed [COORD_BITS-1:0]    pixel_x_o,
  output logic signed [COORD_BITS-1:0]    pixel_y_o,
  output logic                            in_window_o,
  output logic                            last_point_o,
  output logic                            span_error_o
);

  localparam int unsigned CLIP_W = blsu_pkg::CLIP_W;
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SPAN_W = $clog2(MAX_POINTS);
  localparam int unsigned ERR_W  = SPAN_W + 3;
  localparam int unsigned CMP_W  = ((COORD_BITS > CLIP_W) ? COORD_BITS : CLIP_W) + 1;
  localparam logic [DIFF_W-1:0] SPAN_MAX = DIFF_W'(MAX_POINTS - 1);

  // Clip registers
  logic [CLIP_W-1:0] clip_w_q, clip_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= blsu_pkg::CLIP_RESET;
      clip_h_q <= blsu_pkg::CLIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blsu_pkg::CFG_CLIP_WIDTH:  clip_w_q <= cfg_wdata_i;
        blsu_pkg::CFG_CLIP_HEIGHT: clip_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Set-up arithmetic on the incoming word
  logic signed [DIFF_W-1:0] dxs, dys;
  logic [DIFF_W-1:0]        adx, ady;
  logic                     ovf, dir_x, dir_y;

  always_comb begin
    dxs   = $signed({x_end_i[COORD_BITS-1], x_end_i})
          - $signed({x_start_i[COORD_BITS-1], x_start_i});
    dys   = $signed({y_end_i[COORD_BITS-1], y_end_i})
          - $signed({y_start_i[COORD_BITS-1], y_start_i});
    adx   = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    ady   = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
    ovf   = (adx > SPAN_MAX) || (ady > SPAN_MAX);
    // equal coordinates count as a negative direction
    dir_x = dxs[DIFF_W-1] || (dxs == '0);
    dir_y = dys[DIFF_W-1] || (dys == '0);
  end

  // Line state
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic signed [COORD_BITS-1:0] cur_x_d, cur_y_d;
  logic signed [ERR_W-1:0]      err_q, err_d, ndy_q, dx_ext, ndy_init;
  logic [SPAN_W-1:0]            dx_q;
  logic [1:0]                   dirs_q;
  logic                         ovf_q;
  logic signed [ERR_W:0]        e2, ndy_e2, dx_e2;
  logic                         step_x, step_y;

  function automatic logic signed [ERR_W-1:0] dx_ext_init(input logic [SPAN_W-1:0] span);
    return $signed(ERR_W'(span));
  endfunction

  always_comb begin
    dx_ext   = $signed(ERR_W'(dx_q));
    ndy_init = $signed(ERR_W'(0) - ERR_W'(ady[SPAN_W-1:0]));
    e2       = $signed({err_q, 1'b0});
    ndy_e2   = $signed({ndy_q[ERR_W-1], ndy_q});
    dx_e2    = $signed({dx_ext[ERR_W-1], dx_ext});
    step_x   = (e2 >= ndy_e2);
    step_y   = (e2 <= dx_e2);
    err_d    = err_q + (step_x ? ndy_q : ERR_W'(0)) + (step_y ? dx_ext : ERR_W'(0));
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    if (step_x) begin
      cur_x_d = dirs_q[0] ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
    end
    if (step_y) begin
      cur_y_d = dirs_q[1] ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovf_q <= ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dx_q    <= '0;
      ndy_q   <= '0;
      err_q   <= '0;
      dirs_q  <= '0;
    end else if (cmd_i.load) begin
      cur_x_q <= x_start_i;
      cur_y_q <= y_start_i;
      tgt_x_q <= x_end_i;
      tgt_y_q <= y_end_i;
      dx_q    <= adx[SPAN_W-1:0];
      ndy_q   <= ndy_init;
      err_q   <= dx_ext_init(adx[SPAN_W-1:0]) + ndy_init;
      dirs_q  <= {dir_y, dir_x};
    end else if (cmd_i.step) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
    end
  end

  // Window test in a width that holds both operands
  logic signed [CMP_W-1:0] x_cmp, y_cmp, w_cmp, h_cmp;
  logic                    vis;

  always_comb begin
    x_cmp = $signed({{(CMP_W-COORD_BITS){cur_x_q[COORD_BITS-1]}}, cur_x_q});
    y_cmp = $signed({{(CMP_W-COORD_BITS){cur_y_q[COORD_BITS-1]}}, cur_y_q});
    w_cmp = $signed({{(CMP_W-CLIP_W){1'b0}}, clip_w_q});
    h_cmp = $signed({{(CMP_W-CLIP_W){1'b0}}, clip_h_q});
    vis   = (x_cmp > $signed(CMP_W'(0))) && (x_cmp < w_cmp)
         && (y_cmp > $signed(CMP_W'(0))) && (y_cmp < h_cmp);
  end

  assign pixel_x_o     = cur_x_q;
  assign pixel_y_o     = cur_y_q;
  assign in_window_o   = vis && !ovf_q;
  assign last_point_o  = ovf_q || ((cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q));
  assign span_error_o  = ovf_q;
  assign status_o.last = last_point_o;

endmodule
